>>> rtl/scrl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the squared clipped-ReLU output layer.
// No dependencies; every other file of the block refers to it by scoped name.
package scrl_pkg;

  // Field widths of the input and result beats
  localparam int CMD_W    = 2;
  localparam int BUCKET_W = 3;
  localparam int POS_W    = 11;
  localparam int VAL_W    = 16;
  localparam int SCORE_W  = 32;

  // Width of a lane product: 17-bit unsigned square times 16-bit signed weight
  localparam int PROD_W = 33;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_WEIGHT = 2'd0,
    CMD_LOAD_BIAS   = 2'd1,
    CMD_FEED        = 2'd2
  } cmd_t;

  // Reciprocal of 255: (x * DIV255_MUL) >> DIV255_SHIFT is exact for 32-bit x
  localparam logic [31:0] DIV255_MUL   = 32'h8080_8081;
  localparam int          DIV255_SHIFT = 39;

  // Reciprocal of 51: (y * DIV51_MUL) >> 32 is exact for y below 2^25.
  // 400 / 16320 reduces to 5 / 204, and x / 204 is (x >> 2) / 51.
  localparam logic [26:0] DIV51_MUL   = 27'd84215046;
  localparam int          DIV51_SHIFT = 32;

  // Control that travels beside the lane products into the merge stage
  typedef struct packed {
    logic                    add_en;
    logic                    emit;
    logic signed [VAL_W-1:0] bias;
  } merge_ctrl_t;

endpackage

>>> rtl/scrl_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the feed beats and the score beats.
// Depends on scrl_pkg for field widths.
interface scrl_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [scrl_pkg::CMD_W-1:0]            command;
  logic [scrl_pkg::BUCKET_W-1:0]         bucket;
  logic [scrl_pkg::POS_W-1:0]            position;
  logic signed [scrl_pkg::VAL_W-1:0]     weight_value;
  logic signed [scrl_pkg::VAL_W-1:0]     stm_value;
  logic signed [scrl_pkg::VAL_W-1:0]     ntm_value;
  logic                                  last;

  modport source (output valid, command, bucket, position, weight_value, stm_value,
                  ntm_value, last, input ready);
  modport sink   (input valid, command, bucket, position, weight_value, stm_value,
                  ntm_value, last, output ready);
endinterface

interface scrl_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [scrl_pkg::SCORE_W-1:0] score;

  modport source (output valid, score, input ready);
  modport sink   (input valid, score, output ready);
endinterface

>>> rtl/scrl_lane.sv
`timescale 1ns / 1ps
// One lane: weight memory bank, clamp and square of the element, product by weight.
// Depends on scrl_pkg for widths.
module scrl_lane #(
  parameter int DEPTH  = 8192,
  parameter int ADDR_W = 13
) (
  input  logic                                 clk,
  input  logic                                 adv,
  input  logic                                 wr_en,
  input  logic [ADDR_W-1:0]                    addr,
  input  logic signed [scrl_pkg::VAL_W-1:0]    wr_data,
  input  logic signed [scrl_pkg::VAL_W-1:0]    value,
  output logic signed [scrl_pkg::PROD_W-1:0]   prod
);

  logic signed [scrl_pkg::VAL_W-1:0]  mem_r [DEPTH];
  logic signed [scrl_pkg::VAL_W-1:0]  w1_r;
  logic signed [scrl_pkg::VAL_W-1:0]  val1_r;
  logic signed [scrl_pkg::VAL_W-1:0]  w2_r;
  logic [15:0]                        sq2_r;
  logic [15:0]                        sq_nxt;
  logic [7:0]                         clip;
  logic signed [scrl_pkg::PROD_W-1:0] prod3_r;
  logic signed [scrl_pkg::PROD_W-1:0] prod_nxt;

  // Write on a load beat, read the weight for the beat being taken
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[addr] <= wr_data;
    end
    if (adv) begin
      w1_r   <= mem_r[addr];
      val1_r <= value;
    end
  end

  // Clamp to 0..255 and square
  always_comb begin
    if (val1_r[scrl_pkg::VAL_W-1]) begin
      clip = 8'd0;
    end else if (|val1_r[scrl_pkg::VAL_W-2:8]) begin
      clip = 8'd255;
    end else begin
      clip = val1_r[7:0];
    end
    sq_nxt = 16'(clip) * 16'(clip);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq2_r <= sq_nxt;
      w2_r  <= w1_r;
    end
  end

  // Weight the square
  assign prod_nxt = signed'({1'b0, sq2_r}) * w2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      prod3_r <= prod_nxt;
    end
  end

  assign prod = prod3_r;

endmodule

>>> rtl/scrl_merge.sv
`timescale 1ns / 1ps
// Merge stage: adds both lane products into the wrapping running sum, then scales
// the finished sum (divide by 255, add bias, times 400 / 16320). Depends on scrl_pkg.
module scrl_merge (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  scrl_pkg::merge_ctrl_t                ctrl,
  input  logic signed [scrl_pkg::PROD_W-1:0]   prod_stm,
  input  logic signed [scrl_pkg::PROD_W-1:0]   prod_ntm,
  output logic                                 fin_valid,
  output logic signed [scrl_pkg::SCORE_W-1:0]  fin_score
);

  logic [31:0]        sum_r;
  logic [31:0]        sum_add;
  logic               v4_r, v5_r, v6_r, v7_r, v8_r;
  logic [31:0]        sum4_r;
  logic signed [15:0] bias4_r, bias5_r, bias6_r;
  logic               neg5_r, neg6_r, neg7_r, neg8_r;
  logic [31:0]        mag5_r;
  logic [63:0]        prod6_r;
  logic [27:0]        x7_r;
  logic [52:0]        prod8_r;
  logic [24:0]        q1;
  logic signed [25:0] s_div, t_sum, t_mag;
  logic [20:0]        q2;

  // Accumulate, hand the finished sum on and clear on the last element
  assign sum_add = sum_r + prod_stm[31:0] + prod_ntm[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      v6_r  <= 1'b0;
      v7_r  <= 1'b0;
      v8_r  <= 1'b0;
    end else if (adv) begin
      if (ctrl.emit) begin
        sum_r <= '0;
      end else if (ctrl.add_en) begin
        sum_r <= sum_add;
      end
      v4_r <= ctrl.emit;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  // Magnitude for truncating division
  always_ff @(posedge clk) begin
    if (adv) begin
      sum4_r  <= ctrl.add_en ? sum_add : sum_r;
      bias4_r <= ctrl.bias;
      neg5_r  <= sum4_r[31];
      mag5_r  <= sum4_r[31] ? (~sum4_r + 32'd1) : sum4_r;
      bias5_r <= bias4_r;
      prod6_r <= 64'(mag5_r) * 64'(scrl_pkg::DIV255_MUL);
      neg6_r  <= neg5_r;
      bias6_r <= bias5_r;
    end
  end

  // Restore sign, add bias, take magnitude again and times five
  always_comb begin
    q1    = prod6_r[scrl_pkg::DIV255_SHIFT +: 25];
    s_div = neg6_r ? -signed'({1'b0, q1}) : signed'({1'b0, q1});
    t_sum = s_div + 26'(bias6_r);
    t_mag = t_sum[25] ? -t_sum : t_sum;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg7_r  <= t_sum[25];
      x7_r    <= {2'b00, t_mag[25:0]} + {t_mag[25:0], 2'b00};
      neg8_r  <= neg7_r;
      prod8_r <= 53'(x7_r[27:2]) * 53'(scrl_pkg::DIV51_MUL);
    end
  end

  assign q2        = prod8_r[scrl_pkg::DIV51_SHIFT +: 21];
  assign fin_valid = v8_r;
  assign fin_score = neg8_r ? (32'sd0 - signed'(32'(q2))) : signed'(32'(q2));

endmodule

>>> rtl/screlu_output_layer_eval.sv
`timescale 1ns / 1ps
// A score beat follows the beat with the last element through the control, merge and output registers.
// Throughput: one beat per cycle; the pipeline stalls only while a score waits
// unaccepted at the output and another score stands right behind it.
// Each lane reads its weight memory bank once per beat, which sets that rate.
// Reset (rst_n low, synchronous) clears the running sum and all valid bits;
// weight and bias stores hold nothing defined until loaded.
module screlu_output_layer_eval #(
  parameter int HIDDEN_SIZE  = 1024,
  parameter int BUCKET_COUNT = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  scrl_in_if.sink    in_bus,
  scrl_out_if.source out_bus
);

  localparam int LaneDepth = BUCKET_COUNT * HIDDEN_SIZE;
  localparam int AddrW     = (LaneDepth > 1) ? $clog2(LaneDepth) : 1;
  localparam int BiasW     = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;

  logic                                adv;
  logic                                accept;
  logic                                is_wload, is_bload, is_feed;
  logic [4:0]                          bucket_ext;
  logic                                bucket_ok;
  logic [13:0]                         pos14, off14;
  logic                                stm_side, ntm_side;
  logic [18:0]                         addr_full;
  logic [AddrW-1:0]                    addr;
  logic signed [15:0]                  bias_r [BUCKET_COUNT];
  logic signed [15:0]                  bias_rd;
  scrl_pkg::merge_ctrl_t               ctrl_nxt, ctrl1_r, ctrl2_r, ctrl3_r;
  logic signed [scrl_pkg::PROD_W-1:0]  prod_stm, prod_ntm;
  logic                                fin_valid;
  logic signed [scrl_pkg::SCORE_W-1:0] fin_score;
  logic                                out_valid_r;
  logic signed [scrl_pkg::SCORE_W-1:0] score_r;

  // Hold everything only when a finished score cannot move on
  assign adv          = !(fin_valid && out_valid_r && !out_bus.ready);
  assign in_bus.ready = adv;
  assign accept       = in_bus.valid && adv;

  // Decode the command
  always_comb begin
    is_wload = 1'b0;
    is_bload = 1'b0;
    is_feed  = 1'b0;
    unique case (scrl_pkg::cmd_t'(in_bus.command))
      scrl_pkg::CMD_LOAD_WEIGHT: is_wload = 1'b1;
      scrl_pkg::CMD_LOAD_BIAS:   is_bload = 1'b1;
      scrl_pkg::CMD_FEED:        is_feed  = 1'b1;
      default: ;
    endcase
  end

  // Address within a lane bank: bucket * HIDDEN_SIZE + offset
  always_comb begin
    bucket_ext = {2'b00, in_bus.bucket};
    bucket_ok  = 6'(bucket_ext) < 6'(BUCKET_COUNT);
    pos14      = {3'b000, in_bus.position};
    stm_side   = pos14 < 14'(HIDDEN_SIZE);
    ntm_side   = !stm_side && (pos14 < 14'(2 * HIDDEN_SIZE));
    off14      = stm_side ? pos14 : (pos14 - 14'(HIDDEN_SIZE));
    addr_full  = 19'(bucket_ext) * 19'(HIDDEN_SIZE) + 19'(off14);
    addr       = addr_full[AddrW-1:0];
  end

  // Bias store
  always_ff @(posedge clk) begin
    if (accept && is_bload && bucket_ok) begin
      bias_r[bucket_ext[BiasW-1:0]] <= in_bus.weight_value;
    end
  end

  assign bias_rd = bucket_ok ? bias_r[bucket_ext[BiasW-1:0]] : 16'sd0;

  // Control beside the lanes, three stages to the merge
  always_comb begin
    ctrl_nxt.add_en = accept && is_feed && bucket_ok && stm_side;
    ctrl_nxt.emit   = accept && is_feed && in_bus.last;
    ctrl_nxt.bias   = bias_rd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl1_r <= '0;
      ctrl2_r <= '0;
      ctrl3_r <= '0;
    end else if (adv) begin
      ctrl1_r <= ctrl_nxt;
      ctrl2_r <= ctrl1_r;
      ctrl3_r <= ctrl2_r;
    end
  end

  scrl_lane #(
    .DEPTH  (LaneDepth),
    .ADDR_W (AddrW)
  ) u_lane_stm (
    .clk     (clk),
    .adv     (adv),
    .wr_en   (accept && is_wload && bucket_ok && stm_side),
    .addr    (addr),
    .wr_data (in_bus.weight_value),
    .value   (in_bus.stm_value),
    .prod    (prod_stm)
  );

  scrl_lane #(
    .DEPTH  (LaneDepth),
    .ADDR_W (AddrW)
  ) u_lane_ntm (
    .clk     (clk),
    .adv     (adv),
    .wr_en   (accept && is_wload && bucket_ok && ntm_side),
    .addr    (addr),
    .wr_data (in_bus.weight_value),
    .value   (in_bus.ntm_value),
    .prod    (prod_ntm)
  );

  scrl_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .ctrl      (ctrl3_r),
    .prod_stm  (prod_stm),
    .prod_ntm  (prod_ntm),
    .fin_valid (fin_valid),
    .fin_score (fin_score)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && fin_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && fin_valid) begin
      score_r <= fin_score;
    end
  end

  assign out_bus.valid = out_valid_r;
  assign out_bus.score = score_r;

endmodule

>>> rtl/scrl_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the output layer, attached to the top level by bind.
// Depends on screlu_output_layer_eval and its channel interfaces.
module scrl_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [scrl_pkg::SCORE_W-1:0] score
);

  // Keep a stalled score beat offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("score beat dropped while stalled");

  // Keep a stalled score unchanged
  a_score_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(score))
    else $error("score changed while stalled");

  // Input side only waits when the output register is full and blocked
  a_ready_free: assert property (@(posedge clk)
    (out_ready || !out_valid) |-> in_ready)
    else $error("input stalled without a blocked score");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("score beat offered after reset");

  // A score beat never rises straight out of reset
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(rst_n))
    else $error("score beat appeared straight out of reset");

endmodule

bind screlu_output_layer_eval scrl_checker u_scrl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_bus.ready),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .score     (out_bus.score)
);
